/* hw/rtl/fzc4_pkg.sv */
// ---------------------------------------------------------------------------
// fzc4_pkg
// Shared types and constants for the four-channel fractal weight scatter block.
// ---------------------------------------------------------------------------
package fzc4_pkg;

  // Element and layout constants
  localparam int ELEM_BITS       = 16;
  localparam int PADDED_CHANNELS = 4;
  localparam logic [15:0] VALUE_MASK =
    (ELEM_BITS < 16) ? 16'((1 << ELEM_BITS) - 1) : 16'hFFFF;

  // Queue depths
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // Field widths
  localparam int Z_W    = 18;   // (h*W+w)*4+c
  localparam int N_W    = 16;
  localparam int VAL_W  = 16;
  localparam int ADDR_W = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_BATCH_COUNT   = 3'd0;
  localparam logic [2:0] REG_CHAN_COUNT    = 3'd1;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [2:0] REG_CUBE_IS_32    = 3'd4;

  typedef struct packed {
    logic [15:0] batch_count;
    logic [2:0]  chan_count;
    logic [7:0]  kernel_height;
    logic [7:0]  kernel_width;
    logic        cube_is_32;
  } cfg_t;

  // Classified element handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [Z_W-1:0]   z;
    logic [N_W-1:0]   n;
    logic             last;
  } rec_t;

  // Finished result
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              ovf;
  } res_t;

endpackage

/* hw/rtl/fzc4_fifo.sv */
// ---------------------------------------------------------------------------
// fzc4_fifo
// Small first-word-fall-through queue on a register array.
// ---------------------------------------------------------------------------
module fzc4_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/fzc4_front.sv */
// ---------------------------------------------------------------------------
// fzc4_front
// Takes elements in NCHW order, tracks the position counters and hands a
// classified record (flat z index, kernel index, last flag) to the queue.
// ---------------------------------------------------------------------------
module fzc4_front (
  input  logic          clk,
  input  logic          rst,
  input  fzc4_pkg::cfg_t cfg,
  input  logic          push,
  input  logic [15:0]   elem_value,
  output logic          full,
  output logic          q_push,
  output fzc4_pkg::rec_t q_data,
  input  logic          q_full
);
  import fzc4_pkg::*;

  logic [15:0] pos_n;
  logic [1:0]  pos_c;
  logic [7:0]  pos_h;
  logic [7:0]  pos_w;

  logic [15:0] nn;
  logic [2:0]  cc;
  logic [7:0]  hh;
  logic [7:0]  ww;
  logic        end_w, end_h, end_c, end_n;
  logic        accept;
  logic [15:0] row_w;

  // effective sizes: zero acts as one, channels clamp to four
  always_comb begin
    nn = (cfg.batch_count == '0) ? 16'd1 : cfg.batch_count;
    hh = (cfg.kernel_height == '0) ? 8'd1 : cfg.kernel_height;
    ww = (cfg.kernel_width == '0) ? 8'd1 : cfg.kernel_width;
    if (cfg.chan_count == '0) begin
      cc = 3'd1;
    end else if (cfg.chan_count > 3'd4) begin
      cc = 3'd4;
    end else begin
      cc = cfg.chan_count;
    end
  end

  // end-of-dimension flags (a counter past a shrunk size counts as at end)
  assign end_w = ({1'b0, pos_w} + 9'd1) >= {1'b0, ww};
  assign end_h = ({1'b0, pos_h} + 9'd1) >= {1'b0, hh};
  assign end_c = ({1'b0, pos_c} + 3'd1) >= cc;
  assign end_n = ({1'b0, pos_n} + 17'd1) >= {1'b0, nn};

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  // record build: z = (h*W + w)*4 + c
  assign row_w = 16'(pos_h * ww) + 16'(pos_w);
  always_comb begin
    q_data.value = elem_value & VALUE_MASK;
    q_data.z     = Z_W'(row_w) * Z_W'(PADDED_CHANNELS) + Z_W'(pos_c);
    q_data.n     = pos_n;
    q_data.last  = end_w && end_h && end_c && end_n;
  end

  // position counters, w innermost
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_n <= '0;
      pos_c <= '0;
      pos_h <= '0;
      pos_w <= '0;
    end else if (accept) begin
      if (!end_w) begin
        pos_w <= pos_w + 1'b1;
      end else begin
        pos_w <= '0;
        if (!end_h) begin
          pos_h <= pos_h + 1'b1;
        end else begin
          pos_h <= '0;
          if (!end_c) begin
            pos_c <= pos_c + 1'b1;
          end else begin
            pos_c <= '0;
            pos_n <= end_n ? '0 : pos_n + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/fzc4_back.sv */
// ---------------------------------------------------------------------------
// fzc4_back
// Turns queued records into destination addresses: a multiply stage, then
// the final add and saturation into the result queue.
// ---------------------------------------------------------------------------
module fzc4_back #(
  parameter int OUT_DEPTH = 4,
  localparam int CNT_W = $clog2(OUT_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  fzc4_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  fzc4_pkg::rec_t  q_data,
  output logic           q_pop,
  output logic           o_push,
  output fzc4_pkg::res_t  o_data,
  input  logic           o_full,
  input  logic [CNT_W-1:0] o_count
);
  import fzc4_pkg::*;

  logic [15:0] nn;
  logic [12:0] groups;
  logic [13:0] z_hi;
  logic [4:0]  z_lo;
  logic [26:0] prod_next;
  logic [20:0] base_next;

  // stage 1 registers
  logic        s1_valid;
  logic [26:0] s1_prod;
  logic [20:0] s1_base;
  logic        s1_cube;
  logic [VAL_W-1:0] s1_value;
  logic        s1_last;

  logic [36:0] wide;
  logic [36:0] sum;
  logic        ovf;
  logic [CNT_W:0] room_need;

  // issue only when the result queue can absorb everything in flight
  assign room_need = {1'b0, o_count} + (CNT_W + 1)'(s1_valid);
  assign q_pop     = !q_empty && (room_need < (CNT_W + 1)'(OUT_DEPTH));

  // groups = ceil(N / c0); z split into cube row and column
  always_comb begin
    nn = (cfg.batch_count == '0) ? 16'd1 : cfg.batch_count;
    if (cfg.cube_is_32) begin
      groups = 13'(({1'b0, nn} + 17'd31) >> 5);
      z_hi   = {1'b0, q_data.z[17:5]};
      z_lo   = q_data.z[4:0];
    end else begin
      groups = 13'(({1'b0, nn} + 17'd15) >> 4);
      z_hi   = q_data.z[17:4];
      z_lo   = {1'b0, q_data.z[3:0]};
    end
  end

  // (n/c0)*c0*c0 + (n%c0)*c0 reduces to n*c0
  assign prod_next = 27'(z_hi) * 27'(groups);
  assign base_next = (cfg.cube_is_32 ? {q_data.n, 5'b0} : {1'b0, q_data.n, 4'b0})
                     + 21'(z_lo);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod  <= prod_next;
      s1_base  <= base_next;
      s1_cube  <= cfg.cube_is_32;
      s1_value <= q_data.value;
      s1_last  <= q_data.last;
    end
  end

  // final add and saturation
  assign wide = s1_cube ? {s1_prod, 10'b0} : {2'b0, s1_prod, 8'b0};
  assign sum  = wide + 37'(s1_base);
  assign ovf  = |sum[36:32];

  always_comb begin
    o_data.ovf   = ovf;
    o_data.addr  = ovf ? '1 : sum[31:0];
    o_data.value = s1_value;
    o_data.last  = s1_last;
  end
  assign o_push = s1_valid;

`ifndef SYNTH
  // a finished result always finds room in the result queue
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !o_full)
    else $error("result pushed into a full queue");

  // in-flight plus queued results never exceed the queue depth
  a_credit: assert property (@(posedge clk) disable iff (rst)
    room_need <= (CNT_W + 1)'(OUT_DEPTH))
    else $error("result credit overrun");

  // every issued record reaches the multiply stage next cycle
  a_issue: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_valid)
    else $error("issued record lost");
`endif

endmodule

/* hw/rtl/nchw_to_fractal_z_c04_scatter.sv */
// ---------------------------------------------------------------------------
// nchw_to_fractal_z_c04_scatter
// Four-channel fractal weight layout scatter: element in, element plus address out.
// ---------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: present elem_value with push; a beat is
//   taken when push is high and full is low. Elements arrive in NCHW order.
//   Results are a queue read port: while empty is low the oldest result sits
//   on dest_addr/out_value/last_elem/addr_overflow; pop takes it.
//   Registers are written through cfg_valid/cfg_index/cfg_data (cfg_ready is
//   always high); write them only while no beat is in flight.
//   Path of a taken beat: middle queue, multiply stage, then result queue.
//   Throughput: one element per cycle unless the receiver stalls, set by the
//   front counter update and the two-stage address unit (multiply, add, saturate).
//   When the receiver stalls, the result queue fills, the back end stops
//   issuing, the middle queue fills and full rises; no beat is dropped.
//   Reset (rst, synchronous) empties both queues, clears the position
//   counters and restores the register defaults (N=1, C=4, H=1, W=1, c0=16).
//   After the last element of the tensor the position counters wrap to zero.
// ---------------------------------------------------------------------------
module nchw_to_fractal_z_c04_scatter #(
  parameter int MID_DEPTH = fzc4_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = fzc4_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [15:0] elem_value,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [31:0] dest_addr,
  output logic [15:0] out_value,
  output logic        last_elem,
  output logic        addr_overflow,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fzc4_pkg::*;

  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  cfg_t cfg;
  rec_t f_data;
  rec_t m_data;
  res_t b_data;
  res_t r_data;
  logic f_push, m_full, m_empty, m_pop;
  logic b_push, o_full;
  logic [OUT_CNT_W-1:0] o_count;
  logic [MID_CNT_W-1:0] m_count;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_count   <= 16'd1;
      cfg.chan_count    <= 3'd4;
      cfg.kernel_height <= 8'd1;
      cfg.kernel_width  <= 8'd1;
      cfg.cube_is_32    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BATCH_COUNT:   cfg.batch_count   <= cfg_data;
        REG_CHAN_COUNT:    cfg.chan_count    <= cfg_data[2:0];
        REG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[7:0];
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[7:0];
        REG_CUBE_IS_32:    cfg.cube_is_32    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: position tracking and classification
  fzc4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .elem_value (elem_value),
    .full       (full),
    .q_push     (f_push),
    .q_data     (f_data),
    .q_full     (m_full)
  );

  // queue between front and back
  fzc4_fifo #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_data),
    .full  (m_full),
    .pop   (m_pop),
    .rdata (m_data),
    .empty (m_empty),
    .count (m_count)
  );

  // back: address arithmetic
  fzc4_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (m_empty),
    .q_data  (m_data),
    .q_pop   (m_pop),
    .o_push  (b_push),
    .o_data  (b_data),
    .o_full  (o_full),
    .o_count (o_count)
  );

  // result queue
  fzc4_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_push),
    .wdata (b_data),
    .full  (o_full),
    .pop   (pop),
    .rdata (r_data),
    .empty (empty),
    .count (o_count)
  );

  assign dest_addr     = r_data.addr;
  assign out_value     = r_data.value;
  assign last_elem     = r_data.last;
  assign addr_overflow = r_data.ovf;

`ifndef SYNTH
  // the front stalls exactly when the middle queue holds its full depth
  a_full_track: assert property (@(posedge clk) disable iff (rst)
    full == (m_count == MID_CNT_W'(MID_DEPTH)))
    else $error("full out of step with middle queue");
`endif

endmodule

/* tb/fzc4_scatter_checker.sv */
// ---------------------------------------------------------------------------
// fzc4_scatter_checker
// Watches the element, result and register channels of the four-channel
// fractal weight scatter block, predicts each result beat and compares it
// field by field.
// ---------------------------------------------------------------------------
module fzc4_scatter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] elem_value,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] dest_addr,
  input  logic [15:0] out_value,
  input  logic        last_elem,
  input  logic        addr_overflow,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import fzc4_pkg::*;

  localparam int REPORT_MAX = 10;

  // Shadow registers
  logic [15:0] batch_r;
  logic [2:0]  chan_r;
  logic [7:0]  height_r;
  logic [7:0]  width_r;
  logic        cube32_r;

  // Position of the next element in NCHW order
  logic [15:0] at_n;
  logic [1:0]  at_c;
  logic [7:0]  at_h;
  logic [7:0]  at_w;

  res_t placed_q[$];
  int   mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Destination address of the element at the current position, then step on
  function automatic res_t place_elem(input logic [15:0] v);
    longint unsigned nn, cc, hh, ww, c0, z, grp, addr, n;
    logic end_w, end_h, end_c, end_n;
    res_t r;
    nn = (batch_r == 0) ? 1 : batch_r;
    cc = (chan_r == 0) ? 1 : ((chan_r > 4) ? 4 : chan_r);
    hh = (height_r == 0) ? 1 : height_r;
    ww = (width_r == 0) ? 1 : width_r;
    c0 = cube32_r ? 32 : 16;
    n  = at_n;
    z  = (at_h * ww + at_w) * PADDED_CHANNELS + at_c;
    grp  = (nn + c0 - 1) / c0;
    addr = (z / c0) * (grp * c0 * c0) + (n / c0) * c0 * c0 + (n % c0) * c0 + z % c0;

    // counters at or past their last value count as ended
    end_w = (at_w + 1 >= ww);
    end_h = (at_h + 1 >= hh);
    end_c = (at_c + 1 >= cc);
    end_n = (at_n + 1 >= nn);

    r.ovf   = (addr > 64'hFFFF_FFFF);
    r.addr  = r.ovf ? '1 : addr[31:0];
    r.value = v & VALUE_MASK;
    r.last  = end_w && end_h && end_c && end_n;

    if (!end_w) begin
      at_w = at_w + 8'd1;
    end else begin
      at_w = '0;
      if (!end_h) begin
        at_h = at_h + 8'd1;
      end else begin
        at_h = '0;
        if (!end_c) begin
          at_c = at_c + 2'd1;
        end else begin
          at_c = '0;
          at_n = end_n ? '0 : at_n + 16'd1;
        end
      end
    end
    return r;
  endfunction

  // Sample all three channels on the rising edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      batch_r  = 16'd1;
      chan_r   = 3'd4;
      height_r = 8'd1;
      width_r  = 8'd1;
      cube32_r = 1'b0;
      at_n = '0;
      at_c = '0;
      at_h = '0;
      at_w = '0;
      placed_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BATCH_COUNT:   batch_r  = cfg_data;
          REG_CHAN_COUNT:    chan_r   = cfg_data[2:0];
          REG_KERNEL_HEIGHT: height_r = cfg_data[7:0];
          REG_KERNEL_WIDTH:  width_r  = cfg_data[7:0];
          REG_CUBE_IS_32:    cube32_r = cfg_data[0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (pop && !empty) begin
        if (placed_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result beat with none expected: addr=%h value=%h last=%b ovf=%b",
                     $time, dest_addr, out_value, last_elem, addr_overflow);
          mismatches++;
        end else begin
          want = placed_q.pop_front();
          if (dest_addr !== want.addr || out_value !== want.value ||
              last_elem !== want.last || addr_overflow !== want.ovf) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: result mismatch: exp addr=%h value=%h last=%b ovf=%b, %s",
                       $time, want.addr, want.value, want.last, want.ovf,
                       $sformatf("got addr=%h value=%h last=%b ovf=%b",
                                 dest_addr, out_value, last_elem, addr_overflow));
            mismatches++;
          end
        end
      end

      // element beat
      if (push && !full)
        placed_q.insert(placed_q.size(), place_elem(elem_value));
    end
    pending    <= placed_q.size();
    fail_count <= mismatches;
  end

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for nchw_to_fractal_z_c04_scatter: directed layouts,
// a deep-position walk that saturates the address, then random tensors under
// random sender and receiver gaps; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
  import fzc4_pkg::*;

  localparam int ELEM_TARGET = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 4;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;  // indexes above the last register

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [15:0] elem_value;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] dest_addr;
  logic [15:0] out_value;
  logic        last_elem;
  logic        addr_overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_cnt;
  int sent;
  int walks;
  int pop_hold = 0;
  bit send_steady;
  bit recv_steady = 1'b0;

  nchw_to_fractal_z_c04_scatter dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .elem_value(elem_value),
    .empty(empty), .pop(pop), .dest_addr(dest_addr), .out_value(out_value),
    .last_elem(last_elem), .addr_overflow(addr_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fzc4_scatter_checker chk (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .elem_value(elem_value),
    .empty(empty), .pop(pop), .dest_addr(dest_addr), .out_value(out_value),
    .last_elem(last_elem), .addr_overflow(addr_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // 12-unit clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_batch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'd1;
    if (r < 25) return 16'hFFFF;
    if (r < 30) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  function automatic logic [7:0] rand_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 15) return 8'hFF;
    if (r < 22) return 8'($urandom);
    return 8'($urandom_range(1, 6));
  endfunction

  // Receiver: pop with random stalls
  always @(negedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= recv_steady ? 0 : pick_gap();
    end
  end

  // One element beat, after an optional gap
  task automatic send_elem(input logic [15:0] v);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push       <= 1'b1;
    elem_value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_elem(16'($urandom));
      sent++;
    end
  endtask

  // Register write; junk above the register width now and then
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val, input int width);
    logic [15:0] data;
    data = val;
    if (width < 16 && $urandom_range(0, 3) == 0)
      data = val | (16'($urandom) << width);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] n, input logic [2:0] c, input logic [7:0] h,
                           input logic [7:0] w, input logic c32);
    write_reg(REG_BATCH_COUNT, n, 16);
    write_reg(REG_CHAN_COUNT, 16'(c), 3);
    write_reg(REG_KERNEL_HEIGHT, 16'(h), 8);
    write_reg(REG_KERNEL_WIDTH, 16'(w), 8);
    write_reg(REG_CUBE_IS_32, 16'(c32), 1);
  endtask

  // Stop sending and let every predicted result drain
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Walk pos_h high with W=1, then widen W so z is large and the address saturates
  task automatic deep_walk();
    write_all(16'd1, 3'd1, 8'd1, 8'd1, 1'b0);
    send_random(1);                       // all counters end: positions back to zero
    wait_idle();
    write_all(16'($urandom_range(32768, 65535)), 3'd4, 8'd255, 8'd1, 1'($urandom));
    send_random(254);
    wait_idle();
    write_reg(REG_KERNEL_WIDTH, 16'd255, 8);
    send_random(24);
    walks++;
  endtask

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("nchw_to_fractal_z_c04_scatter verification failed");
    $finish;
  end

  initial begin
    int n_items;
    rst         = 1'b1;
    push        = 1'b0;
    elem_value  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sent        = 0;
    walks       = 0;
    send_steady = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: one kernel, four channels, 1x1
    send_elem(16'h0000);
    send_elem(16'hFFFF);
    send_elem(16'hAAAA);
    send_elem(16'h5555);
    wait_idle();

    // zero sizes act as one; every element is the last
    write_all(16'd0, 3'd0, 8'd0, 8'd0, 1'b1);
    send_elem(16'h8001);
    send_elem(16'h7FFE);
    wait_idle();

    // channel count above four, odd batch, small kernel
    write_all(16'd17, 3'd7, 8'd2, 8'd3, 1'b0);
    repeat (8) send_elem(16'($urandom));
    wait_idle();

    // largest sizes, 32-wide cube, positions kept from before
    write_all(16'hFFFF, 3'd4, 8'hFF, 8'hFF, 1'b1);
    repeat (4) send_elem(16'($urandom));
    wait_idle();

    // shrink width below the current position
    write_reg(REG_KERNEL_WIDTH, 16'd2, 8);
    repeat (3) send_elem(16'($urandom));

    // random part
    while (sent < ELEM_TARGET) begin
      wait_idle();
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      if (walks == 0 || (walks < 3 && $urandom_range(0, 11) == 0)) begin
        deep_walk();
      end else begin
        if ($urandom_range(0, 9) < 6) write_reg(REG_BATCH_COUNT, rand_batch(), 16);
        if ($urandom_range(0, 9) < 6)
          write_reg(REG_CHAN_COUNT, 16'($urandom_range(0, 7)), 3);
        if ($urandom_range(0, 9) < 6) write_reg(REG_KERNEL_HEIGHT, 16'(rand_extent()), 8);
        if ($urandom_range(0, 9) < 6) write_reg(REG_KERNEL_WIDTH, 16'(rand_extent()), 8);
        if ($urandom_range(0, 9) < 6) write_reg(REG_CUBE_IS_32, 16'($urandom_range(0, 1)), 1);
        if ($urandom_range(0, 9) == 0)
          write_reg(REG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom), 16);
        n_items = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                              : $urandom_range(1, 60);
        repeat (n_items) begin
          // occasional drain mid-tensor
          if ($urandom_range(0, 39) == 0) wait_idle();
          send_random(1);
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("nchw_to_fractal_z_c04_scatter verification clean");
    end else begin
      $display("nchw_to_fractal_z_c04_scatter verification failed");
    end
    $finish;
  end

endmodule
